[rtl/core/dpst_pkg.sv]
// Shared types and constants of the decimal pair sum text engine.
// No dependencies; used by the interfaces' users, controller, datapath and top.
`default_nettype none

package dpst_pkg;

    // ASCII codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // output character select
    typedef logic [1:0] t_out_sel;
    localparam t_out_sel SEL_MINUS = 2'd0;
    localparam t_out_sel SEL_DIGIT = 2'd1;
    localparam t_out_sel SEL_NL    = 2'd2;

    // decimal digits of 2^(w-1), the largest magnitude of a signed w-bit sum
    function automatic int ndig(input int w);
        return ((w - 1) * 30103) / 100000 + 1;
    endfunction

    typedef struct packed {
        logic     start_first;   // first_value <= digit
        logic     acc_first;     // first_value <= first_value*10 + digit
        logic     start_second;
        logic     acc_second;
        logic     clear_vals;
        logic     capture_sum;
        logic     load_mag;      // |sum| into shifter, BCD cleared
        logic     conv_step;     // one double-dabble step
        logic     next_digit;    // drop top BCD digit
        logic     out_load;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic in_digit;
        logic sum_neg;
        logic top_zero;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

[rtl/core/dpst_in_if.sv]
// Input channel: character byte and end-of-stream flag with valid/ready.
// Standalone, no dependencies.
`default_nettype none

interface dpst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_stream;

    modport source (output valid, output char_byte, output end_of_stream, input ready);
    modport sink   (input valid, input char_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

[rtl/core/dpst_out_if.sv]
// Output channel: one text character per request, last marks the newline.
// Standalone, no dependencies.
`default_nettype none

interface dpst_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/dpst_dp.sv]
// Datapath: accumulators, sum, double-dabble converter, output register.
// Depends on dpst_pkg.
`default_nettype none

module dpst_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [7:0]     i_char_byte,
    input  wire dpst_pkg::t_cmd i_cmd,
    output dpst_pkg::t_status   o_stat,
    input  wire logic           i_out_ready,
    output logic                o_out_valid,
    output logic [7:0]          o_out_byte,
    output logic                o_out_last
);
    localparam int NDIG = dpst_pkg::ndig(VALUE_WIDTH);
    localparam int BW   = NDIG * 4;

    logic [VALUE_WIDTH-1:0] r_first, r_second, r_sum, r_bin;
    logic [BW-1:0]          r_bcd;
    logic [BW-1:0]          w_bcd_adj;
    logic [3:0]             w_d;
    logic [VALUE_WIDTH-1:0] w_d_ext;
    logic [3:0]             w_top;
    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    logic                   r_out_last;

    assign w_d     = 4'(i_char_byte - dpst_pkg::CH_0);
    assign w_d_ext = {{(VALUE_WIDTH-4){1'b0}}, w_d};
    assign w_top   = r_bcd[BW-1 -: 4];

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                w_bcd_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                w_bcd_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
        end else if (i_cmd.clear_vals) begin
            r_first  <= '0;
            r_second <= '0;
        end else begin
            if (i_cmd.start_first) begin
                r_first <= w_d_ext;
            end else if (i_cmd.acc_first) begin
                r_first <= (r_first << 3) + (r_first << 1) + w_d_ext;
            end
            if (i_cmd.start_second) begin
                r_second <= w_d_ext;
            end else if (i_cmd.acc_second) begin
                r_second <= (r_second << 3) + (r_second << 1) + w_d_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_sum) begin
            r_sum <= r_first + r_second;
        end
        if (i_cmd.load_mag) begin
            r_bin <= r_sum[VALUE_WIDTH-1] ? (~r_sum) + 1'b1 : r_sum;
            r_bcd <= '0;
        end else if (i_cmd.conv_step) begin
            r_bin <= r_bin << 1;
            r_bcd <= {w_bcd_adj[BW-2:0], r_bin[VALUE_WIDTH-1]};
        end else if (i_cmd.next_digit) begin
            r_bcd <= r_bcd << 4;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                dpst_pkg::SEL_MINUS: r_out_byte <= dpst_pkg::CH_MINUS;
                dpst_pkg::SEL_DIGIT: r_out_byte <= {4'h3, w_top};
                default:             r_out_byte <= dpst_pkg::CH_NL;
            endcase
            r_out_last <= (i_cmd.out_sel == dpst_pkg::SEL_NL);
        end
    end

    assign o_stat.in_digit = (i_char_byte >= dpst_pkg::CH_0) && (i_char_byte <= dpst_pkg::CH_9);
    assign o_stat.sum_neg  = r_sum[VALUE_WIDTH-1];
    assign o_stat.top_zero = (w_top == 4'd0);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

[rtl/core/dpst_ctrl.sv]
// Controller: parse phase tracking and sequencing of conversion and emission.
// Depends on dpst_pkg.
`default_nettype none

module dpst_ctrl #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_eos,
    output logic                   o_in_ready,
    input  wire dpst_pkg::t_status i_stat,
    output dpst_pkg::t_cmd         o_cmd
);
    localparam int NDIG = dpst_pkg::ndig(VALUE_WIDTH);
    localparam int CW   = $clog2(VALUE_WIDTH);
    localparam int DW   = $clog2(NDIG);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ABS    = 3'd1;
    localparam logic [2:0] S_CONV   = 3'd2;
    localparam logic [2:0] S_SIGN   = 3'd3;
    localparam logic [2:0] S_DIGITS = 3'd4;
    localparam logic [2:0] S_NL     = 3'd5;

    localparam logic [1:0] PH_SKIP1 = 2'd0;
    localparam logic [1:0] PH_NUM1  = 2'd1;
    localparam logic [1:0] PH_SKIP2 = 2'd2;
    localparam logic [1:0] PH_NUM2  = 2'd3;

    logic [2:0]    r_state, n_state;
    logic [1:0]    r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_dcnt, n_dcnt;
    logic          r_started, n_started;
    logic          w_last_digit;

    assign w_last_digit = (r_dcnt == DW'(NDIG - 1));

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_dcnt    = r_dcnt;
        n_started = r_started;
        o_cmd     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_eos) begin
                        if (r_phase == PH_SKIP2 || r_phase == PH_NUM2) begin
                            o_cmd.capture_sum = 1'b1;
                            n_state = S_ABS;
                        end
                        o_cmd.clear_vals = 1'b1;
                        n_phase = PH_SKIP1;
                    end else begin
                        unique case (r_phase)
                            PH_SKIP1: begin
                                if (i_stat.in_digit) begin
                                    o_cmd.start_first = 1'b1;
                                    n_phase = PH_NUM1;
                                end
                            end
                            PH_NUM1: begin
                                if (i_stat.in_digit) begin
                                    o_cmd.acc_first = 1'b1;
                                end else begin
                                    n_phase = PH_SKIP2;
                                end
                            end
                            PH_SKIP2: begin
                                if (i_stat.in_digit) begin
                                    o_cmd.start_second = 1'b1;
                                    n_phase = PH_NUM2;
                                end
                            end
                            default: begin
                                if (i_stat.in_digit) begin
                                    o_cmd.acc_second = 1'b1;
                                end else begin
                                    o_cmd.capture_sum = 1'b1;
                                    o_cmd.clear_vals  = 1'b1;
                                    n_phase = PH_SKIP1;
                                    n_state = S_ABS;
                                end
                            end
                        endcase
                    end
                end
            end
            S_ABS: begin
                o_cmd.load_mag = 1'b1;
                n_cnt   = '0;
                n_state = S_CONV;
            end
            S_CONV: begin
                o_cmd.conv_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(VALUE_WIDTH - 1)) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                n_dcnt    = '0;
                n_started = 1'b0;
                if (!i_stat.sum_neg) begin
                    n_state = S_DIGITS;
                end else if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = dpst_pkg::SEL_MINUS;
                    n_state = S_DIGITS;
                end
            end
            S_DIGITS: begin
                if (i_stat.top_zero && !r_started && !w_last_digit) begin
                    // leading zero: drop it without output
                    o_cmd.next_digit = 1'b1;
                    n_dcnt = r_dcnt + 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_sel    = dpst_pkg::SEL_DIGIT;
                    o_cmd.next_digit = 1'b1;
                    n_started = 1'b1;
                    if (w_last_digit) begin
                        n_state = S_NL;
                    end else begin
                        n_dcnt = r_dcnt + 1'b1;
                    end
                end
            end
            S_NL: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = dpst_pkg::SEL_NL;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_SKIP1;
            r_cnt     <= '0;
            r_dcnt    <= '0;
            r_started <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_dcnt    <= n_dcnt;
            r_started <= n_started;
        end
    end

endmodule

`default_nettype wire

[rtl/core/decimal_pair_sum_text_engine_top.sv]
// Top level of the decimal pair sum text engine: controller plus datapath.
// Depends on dpst_pkg, dpst_in_if, dpst_out_if, dpst_ctrl, dpst_dp.
//
//  port   dir  payload                         request
//  i_in   in   char_byte[7:0], end_of_stream   one received character or close
//  o_out  out  out_byte[7:0], last             one text character of a sum
//
// A character that completes no pair is taken while the sequencer stays idle.
// A character that ends a pair (or a close after the first number) is followed by
// capture and magnitude load, one double-dabble step per bit, the sign, one step
// per BCD digit and the newline before the next request is taken.
// The output register lets the newline wait while the next request is taken.
// Reset is synchronous, active low; a stalled sink holds the sequencer.
`default_nettype none

module decimal_pair_sum_text_engine_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dpst_in_if.sink     i_in,
    dpst_out_if.source  o_out
);
    dpst_pkg::t_cmd    w_cmd;
    dpst_pkg::t_status w_stat;

    // phase tracking and sequencing
    dpst_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_eos   (i_in.end_of_stream),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // accumulators, converter and output register
    dpst_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_byte (i_in.char_byte),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_last  (o_out.last)
    );

    // never overwrite a character the sink has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_stat.out_free)
        else $error("output register overwritten");

    // a captured sum is always followed by the magnitude load
    a_capture_then_abs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.capture_sum |=> w_cmd.load_mag)
        else $error("sum capture not followed by magnitude load");

    // while taking requests no character is produced
    a_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !w_cmd.out_load && !w_cmd.conv_step)
        else $error("output activity while accepting input");

    // the newline leaves the sequencer ready for the next request
    a_nl_then_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.out_load && w_cmd.out_sel == dpst_pkg::SEL_NL) |=> i_in.ready)
        else $error("not ready after newline");

endmodule

`default_nettype wire
